// File: sv/ipv4fl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fl_pkg
// Shared types, codes and helpers for the IPv4 forwarding lookup unit.
// ----------------------------------------------------------------------------
package ipv4fl_pkg;

	localparam int ROUTE_ENTRIES_DEF    = 64;
	localparam int NEIGHBOR_ENTRIES_DEF = 32;

	localparam int KEY_W   = 32;
	localparam int MAC_W   = 48;
	localparam int PORT_W  = 16;
	localparam int NHOP_W  = 32;
	localparam int NEIGH_W = 2 * MAC_W + PORT_W;

	localparam logic [15:0] MIN_ETH_LEN = 16'd14;
	localparam logic [15:0] MIN_IP_LEN  = 16'd34;
	localparam logic [15:0] ETH_IPV4    = 16'h0800;
	localparam logic [7:0]  TTL_MIN     = 8'd1;
	localparam logic [16:0] CSUM_WRAP   = 17'h0FFFF;

	typedef enum logic [1:0] {
		KIND_PKT      = 2'd0,
		KIND_ROUTE_WR = 2'd1,
		KIND_NEIGH_WR = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		VERDICT_ABORT      = 3'd0,
		VERDICT_DROP       = 3'd1,
		VERDICT_REDIRECT   = 3'd2,
		VERDICT_WRITE_DONE = 3'd3,
		VERDICT_TABLE_FULL = 3'd4
	} verdict_t;

	// table write command
	typedef struct packed {
		logic en;
		logic ins;
	} cam_cmd_t;

	// lookup status
	typedef struct packed {
		logic hit;
		logic full;
	} cam_stat_t;

	// TTL decrement checksum fixup, done on the byte-swapped value
	function automatic logic [15:0] csum_update(input logic [15:0] csum);
		logic [15:0] sw;
		logic [16:0] sum;
		sw  = {csum[7:0], csum[15:8]};
		sum = {1'b0, sw} + 17'd1;
		if (sum >= CSUM_WRAP) begin
			sum = sum + 17'd1;
		end
		return {sum[7:0], sum[15:8]};
	endfunction

endpackage
`default_nettype wire

// File: sv/ipv4fl_cam.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4fl_cam
// Exact-match table in flops: parallel key compare, one-hot data select,
// insert at lowest free slot, update in place, delete by key.
// ----------------------------------------------------------------------------
module ipv4fl_cam #(
	parameter int ENTRIES = ipv4fl_pkg::ROUTE_ENTRIES_DEF,
	parameter int DATA_W  = ipv4fl_pkg::NHOP_W
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic [ipv4fl_pkg::KEY_W-1:0] key,
	input  ipv4fl_pkg::cam_cmd_t       cmd,
	input  logic [DATA_W-1:0]          wr_data,
	output ipv4fl_pkg::cam_stat_t      stat,
	output logic [DATA_W-1:0]          rd_data
);
	import ipv4fl_pkg::*;

	logic [ENTRIES-1:0] valid_q;
	logic [KEY_W-1:0]   keys_q [ENTRIES];
	logic [DATA_W-1:0]  data_q [ENTRIES];

	logic [ENTRIES-1:0] match;
	logic [ENTRIES-1:0] free;
	logic [ENTRIES-1:0] free_first;
	logic [ENTRIES-1:0] sel;

	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (keys_q[i] == key);
		end
	end

	always_comb begin
		rd_data = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			rd_data = rd_data | (data_q[i] & {DATA_W{match[i]}});
		end
	end

	assign free       = ~valid_q;
	assign free_first = free & (~free + ENTRIES'(1));
	assign sel        = (|match) ? match : free_first;

	assign stat.hit  = |match;
	assign stat.full = &valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.en) begin
			if (cmd.ins) begin
				valid_q <= valid_q | sel;
			end else begin
				valid_q <= valid_q & ~match;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < ENTRIES; i++) begin
			if (cmd.en && cmd.ins && sel[i]) begin
				keys_q[i] <= key;
				data_q[i] <= wr_data;
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/ipv4_forward_lookup_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipv4_forward_lookup_unit
// IPv4 forwarding fast path: route and neighbor exact-match lookup, TTL and
// checksum rewrite, MAC rewrite, and table insert/update/delete requests.
// An accepted request loads the input register, and the result register loads
// from it once the result register is free. Throughput: one request per cycle
// unless the output stalls; both table lookups and the rewrite run in the
// single combinational pass between the two registers.
// Reset: both tables empty, packet counter zero, no request in flight.
// ----------------------------------------------------------------------------
module ipv4_forward_lookup_unit #(
	parameter int ROUTE_ENTRIES    = ipv4fl_pkg::ROUTE_ENTRIES_DEF,
	parameter int NEIGHBOR_ENTRIES = ipv4fl_pkg::NEIGHBOR_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  kind,
	input  logic [15:0] frame_length,
	input  logic [15:0] ethertype,
	input  logic [31:0] dst_ip,
	input  logic [7:0]  ttl_in,
	input  logic [15:0] checksum_in,
	input  logic [31:0] next_hop_ip,
	input  logic [47:0] new_dst_mac,
	input  logic [47:0] new_src_mac,
	input  logic [15:0] port_in,
	input  logic        entry_valid,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  verdict,
	output logic [7:0]  ttl_out,
	output logic [15:0] checksum_out,
	output logic [47:0] out_dst_mac,
	output logic [47:0] out_src_mac,
	output logic [15:0] egress_port,
	output logic [63:0] packet_count
);
	import ipv4fl_pkg::*;

	// input stage
	logic              valid_s1;
	logic [1:0]        kind_s1;
	logic [15:0]       frame_length_s1;
	logic [15:0]       ethertype_s1;
	logic [KEY_W-1:0]  dst_ip_s1;
	logic [7:0]        ttl_s1;
	logic [15:0]       checksum_s1;
	logic [NHOP_W-1:0] next_hop_s1;
	logic [MAC_W-1:0]  dst_mac_s1;
	logic [MAC_W-1:0]  src_mac_s1;
	logic [PORT_W-1:0] port_s1;
	logic              entry_valid_s1;

	// result stage
	logic              out_valid_q;
	verdict_t          verdict_q;
	logic [7:0]        ttl_q;
	logic [15:0]       checksum_q;
	logic [MAC_W-1:0]  dst_mac_q;
	logic [MAC_W-1:0]  src_mac_q;
	logic [PORT_W-1:0] port_q;
	logic [63:0]       count_q;
	logic [63:0]       counter_q;

	logic advance;
	logic commit;
	logic is_pkt;

	cam_cmd_t          route_cmd;
	cam_stat_t         route_stat;
	logic [NHOP_W-1:0] route_nh;
	cam_cmd_t          neigh_cmd;
	cam_stat_t         neigh_stat;
	logic [KEY_W-1:0]  neigh_key;
	logic [NEIGH_W-1:0] neigh_wr;
	logic [NEIGH_W-1:0] neigh_rd;

	verdict_t          verdict_d;
	logic [7:0]        ttl_d;
	logic [15:0]       checksum_d;
	logic [MAC_W-1:0]  dst_mac_d;
	logic [MAC_W-1:0]  src_mac_d;
	logic [PORT_W-1:0] port_d;
	logic [63:0]       count_d;

	assign advance  = !out_valid_q || !out_stall;
	assign commit   = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign is_pkt   = (kind_s1 == KIND_PKT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			kind_s1         <= kind;
			frame_length_s1 <= frame_length;
			ethertype_s1    <= ethertype;
			dst_ip_s1       <= dst_ip;
			ttl_s1          <= ttl_in;
			checksum_s1     <= checksum_in;
			next_hop_s1     <= next_hop_ip;
			dst_mac_s1      <= new_dst_mac;
			src_mac_s1      <= new_src_mac;
			port_s1         <= port_in;
			entry_valid_s1  <= entry_valid;
		end
	end

	assign route_cmd.en  = commit && (kind_s1 == KIND_ROUTE_WR);
	assign route_cmd.ins = entry_valid_s1;

	ipv4fl_cam #(
		.ENTRIES (ROUTE_ENTRIES),
		.DATA_W  (NHOP_W)
	) u_route (
		.clk     (clk),
		.arst_n  (arst_n),
		.key     (dst_ip_s1),
		.cmd     (route_cmd),
		.wr_data (next_hop_s1),
		.stat    (route_stat),
		.rd_data (route_nh)
	);

	assign neigh_cmd.en  = commit && (kind_s1 == KIND_NEIGH_WR);
	assign neigh_cmd.ins = entry_valid_s1;
	assign neigh_key     = (kind_s1 == KIND_NEIGH_WR) ? dst_ip_s1 : route_nh;
	assign neigh_wr      = {dst_mac_s1, src_mac_s1, port_s1};

	ipv4fl_cam #(
		.ENTRIES (NEIGHBOR_ENTRIES),
		.DATA_W  (NEIGH_W)
	) u_neigh (
		.clk     (clk),
		.arst_n  (arst_n),
		.key     (neigh_key),
		.cmd     (neigh_cmd),
		.wr_data (neigh_wr),
		.stat    (neigh_stat),
		.rd_data (neigh_rd)
	);

	assign count_d = is_pkt ? counter_q + 64'd1 : counter_q;

	always_comb begin
		verdict_d  = VERDICT_DROP;
		ttl_d      = '0;
		checksum_d = '0;
		dst_mac_d  = '0;
		src_mac_d  = '0;
		port_d     = '0;
		case (kind_s1)
			KIND_PKT: begin
				if (frame_length_s1 < MIN_ETH_LEN) begin
					verdict_d = VERDICT_ABORT;
				end else if (ethertype_s1 != ETH_IPV4) begin
					verdict_d = VERDICT_DROP;
				end else if (frame_length_s1 < MIN_IP_LEN) begin
					verdict_d = VERDICT_ABORT;
				end else if (!route_stat.hit || !neigh_stat.hit || ttl_s1 <= TTL_MIN) begin
					verdict_d = VERDICT_DROP;
				end else begin
					verdict_d  = VERDICT_REDIRECT;
					ttl_d      = ttl_s1 - 8'd1;
					checksum_d = csum_update(checksum_s1);
					{dst_mac_d, src_mac_d, port_d} = neigh_rd;
				end
			end
			KIND_ROUTE_WR: begin
				verdict_d = (entry_valid_s1 && !route_stat.hit && route_stat.full) ?
					VERDICT_TABLE_FULL : VERDICT_WRITE_DONE;
			end
			KIND_NEIGH_WR: begin
				verdict_d = (entry_valid_s1 && !neigh_stat.hit && neigh_stat.full) ?
					VERDICT_TABLE_FULL : VERDICT_WRITE_DONE;
			end
			default: begin
				verdict_d = VERDICT_DROP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			counter_q   <= '0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (commit && is_pkt) begin
				counter_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			verdict_q  <= verdict_d;
			ttl_q      <= ttl_d;
			checksum_q <= checksum_d;
			dst_mac_q  <= dst_mac_d;
			src_mac_q  <= src_mac_d;
			port_q     <= port_d;
			count_q    <= count_d;
		end
	end

	assign out_valid    = out_valid_q;
	assign verdict      = verdict_q;
	assign ttl_out      = ttl_q;
	assign checksum_out = checksum_q;
	assign out_dst_mac  = dst_mac_q;
	assign out_src_mac  = src_mac_q;
	assign egress_port  = port_q;
	assign packet_count = count_q;

`ifndef ASSERT_OFF
	a_counter_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(commit && is_pkt) |=> $stable(counter_q))
		else $error("packet counter moved without a packet");

	a_counter_step: assert property (@(posedge clk) disable iff (!arst_n)
		(commit && is_pkt) |=> counter_q == $past(counter_q) + 64'd1)
		else $error("packet counter did not step by one");

	a_redirect_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q == VERDICT_REDIRECT) |-> ttl_q != 8'd0)
		else $error("redirect with expired ttl");

	a_no_rewrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && verdict_q != VERDICT_REDIRECT) |->
		(ttl_q == 8'd0 && checksum_q == 16'd0 && port_q == '0))
		else $error("rewrite fields set on non-redirect result");
`endif

endmodule
`default_nettype wire

// File: test/tb_ipv4_forward_lookup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ipv4_forward_lookup_unit
// Self-checking bench for the IPv4 forwarding lookup unit. A directed run
// covers frame bounds, ethertype, table misses, TTL expiry, checksum wrap and
// table insert/update/delete. It is followed by random table maintenance
// mixed with mostly well-formed packets aimed mostly at the route pool keys.
// A local copy of both tables and the packet counter predicts every result.
// Requests go in as bursts with random gaps. Results are drained under a
// random stall pattern that includes one long hold-off.
// ----------------------------------------------------------------------------
module tb_ipv4_forward_lookup_unit;
	import ipv4fl_pkg::*;

	localparam int ROUTES          = ROUTE_ENTRIES_DEF;
	localparam int NEIGHS          = NEIGHBOR_ENTRIES_DEF;
	localparam int RANDOM_REQUESTS = 1625;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] frame_length;
		logic [15:0] ethertype;
		logic [31:0] dst_ip;
		logic [7:0]  ttl_in;
		logic [15:0] checksum_in;
		logic [31:0] next_hop_ip;
		logic [47:0] new_dst_mac;
		logic [47:0] new_src_mac;
		logic [15:0] port_in;
		logic        entry_valid;
	} fwd_request_t;

	typedef struct packed {
		verdict_t    verdict;
		logic [7:0]  ttl;
		logic [15:0] csum;
		logic [47:0] dmac;
		logic [47:0] smac;
		logic [15:0] port;
		logic [63:0] count;
	} fwd_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic out_stall = 1'b0;
	fwd_request_t drv = '0;
	logic        in_stall;
	logic        out_valid;
	logic [2:0]  verdict;
	logic [7:0]  ttl_out;
	logic [15:0] checksum_out;
	logic [47:0] out_dst_mac;
	logic [47:0] out_src_mac;
	logic [15:0] egress_port;
	logic [63:0] packet_count;

	// shadow tables
	logic        rt_used [ROUTES] = '{default: 1'b0};
	logic [31:0] rt_key  [ROUTES];
	logic [31:0] rt_nh   [ROUTES];
	logic        nb_used [NEIGHS] = '{default: 1'b0};
	logic [31:0] nb_key  [NEIGHS];
	logic [47:0] nb_dmac [NEIGHS];
	logic [47:0] nb_smac [NEIGHS];
	logic [15:0] nb_port [NEIGHS];
	logic [63:0] pkt_total = '0;

	fwd_request_t request_q[$];
	fwd_result_t  pending_results[$];
	fwd_result_t  predicted;
	fwd_result_t  oldest;
	logic [31:0]  route_pool [80];
	logic [31:0]  hop_pool [40];

	int mismatches = 0;
	int accepted = 0;
	int total_requests = 0;
	int results_seen = 0;
	int burst_left = 0;
	int gap_left = 0;
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;

	ipv4_forward_lookup_unit uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (drv.kind),
		.frame_length (drv.frame_length),
		.ethertype    (drv.ethertype),
		.dst_ip       (drv.dst_ip),
		.ttl_in       (drv.ttl_in),
		.checksum_in  (drv.checksum_in),
		.next_hop_ip  (drv.next_hop_ip),
		.new_dst_mac  (drv.new_dst_mac),
		.new_src_mac  (drv.new_src_mac),
		.port_in      (drv.port_in),
		.entry_valid  (drv.entry_valid),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.verdict      (verdict),
		.ttl_out      (ttl_out),
		.checksum_out (checksum_out),
		.out_dst_mac  (out_dst_mac),
		.out_src_mac  (out_src_mac),
		.egress_port  (egress_port),
		.packet_count (packet_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int route_slot(input logic [31:0] key);
		for (int i = 0; i < ROUTES; i++) begin
			if (rt_used[i] && rt_key[i] == key) return i;
		end
		return -1;
	endfunction

	function automatic int route_free();
		for (int i = 0; i < ROUTES; i++) begin
			if (!rt_used[i]) return i;
		end
		return -1;
	endfunction

	function automatic int neighbor_slot(input logic [31:0] key);
		for (int i = 0; i < NEIGHS; i++) begin
			if (nb_used[i] && nb_key[i] == key) return i;
		end
		return -1;
	endfunction

	function automatic int neighbor_free();
		for (int i = 0; i < NEIGHS; i++) begin
			if (!nb_used[i]) return i;
		end
		return -1;
	endfunction

	task automatic forward_predict(input fwd_request_t r, output fwd_result_t o);
		int ri;
		int ni;
		logic [15:0] sw;
		logic [16:0] sum;
		o = '0;
		ri = -1;
		ni = -1;
		if (r.kind == KIND_PKT) begin
			pkt_total = pkt_total + 64'd1;
			o.count = pkt_total;
			if (r.frame_length < MIN_ETH_LEN) begin
				o.verdict = VERDICT_ABORT;
			end else if (r.ethertype != ETH_IPV4) begin
				o.verdict = VERDICT_DROP;
			end else if (r.frame_length < MIN_IP_LEN) begin
				o.verdict = VERDICT_ABORT;
			end else begin
				ri = route_slot(r.dst_ip);
				if (ri >= 0) ni = neighbor_slot(rt_nh[ri]);
				if (ri < 0 || ni < 0 || r.ttl_in <= 8'd1) begin
					o.verdict = VERDICT_DROP;
				end else begin
					sw = {r.checksum_in[7:0], r.checksum_in[15:8]};
					sum = {1'b0, sw} + 17'd1;
					if (sum >= 17'h0FFFF) sum = sum + 17'd1;
					o.verdict = VERDICT_REDIRECT;
					o.ttl = r.ttl_in - 8'd1;
					o.csum = {sum[7:0], sum[15:8]};
					o.dmac = nb_dmac[ni];
					o.smac = nb_smac[ni];
					o.port = nb_port[ni];
				end
			end
		end else if (r.kind == KIND_ROUTE_WR) begin
			o.count = pkt_total;
			o.verdict = VERDICT_WRITE_DONE;
			ri = route_slot(r.dst_ip);
			if (!r.entry_valid) begin
				if (ri >= 0) rt_used[ri] = 1'b0;
			end else begin
				if (ri < 0) ri = route_free();
				if (ri < 0) begin
					o.verdict = VERDICT_TABLE_FULL;
				end else begin
					rt_used[ri] = 1'b1;
					rt_key[ri] = r.dst_ip;
					rt_nh[ri] = r.next_hop_ip;
				end
			end
		end else if (r.kind == KIND_NEIGH_WR) begin
			o.count = pkt_total;
			o.verdict = VERDICT_WRITE_DONE;
			ni = neighbor_slot(r.dst_ip);
			if (!r.entry_valid) begin
				if (ni >= 0) nb_used[ni] = 1'b0;
			end else begin
				if (ni < 0) ni = neighbor_free();
				if (ni < 0) begin
					o.verdict = VERDICT_TABLE_FULL;
				end else begin
					nb_used[ni] = 1'b1;
					nb_key[ni] = r.dst_ip;
					nb_dmac[ni] = r.new_dst_mac;
					nb_smac[ni] = r.new_src_mac;
					nb_port[ni] = r.port_in;
				end
			end
		end else begin
			o.count = pkt_total;
			o.verdict = VERDICT_DROP;
		end
	endtask

	function automatic fwd_request_t random_request();
		fwd_request_t r;
		logic [63:0] w;
		r.kind = 2'($urandom_range(0, 2));
		r.frame_length = 16'($urandom);
		r.ethertype = 16'($urandom);
		r.dst_ip = $urandom;
		r.ttl_in = 8'($urandom);
		r.checksum_in = 16'($urandom);
		r.next_hop_ip = $urandom;
		w = {$urandom, $urandom};
		r.new_dst_mac = w[47:0];
		w = {$urandom, $urandom};
		r.new_src_mac = w[47:0];
		r.port_in = 16'($urandom);
		r.entry_valid = 1'($urandom);
		return r;
	endfunction

	task automatic add_packet(input logic [15:0] flen, input logic [15:0] etype,
			input logic [31:0] dip, input logic [7:0] ttl, input logic [15:0] csum);
		fwd_request_t r;
		r = random_request();
		r.kind = KIND_PKT;
		r.frame_length = flen;
		r.ethertype = etype;
		r.dst_ip = dip;
		r.ttl_in = ttl;
		r.checksum_in = csum;
		request_q.push_back(r);
	endtask

	task automatic add_route(input logic [31:0] key, input logic [31:0] nh, input logic ins);
		fwd_request_t r;
		r = random_request();
		r.kind = KIND_ROUTE_WR;
		r.dst_ip = key;
		r.next_hop_ip = nh;
		r.entry_valid = ins;
		request_q.push_back(r);
	endtask

	task automatic add_neighbor(input logic [31:0] key, input logic [47:0] dmac,
			input logic [47:0] smac, input logic [15:0] port, input logic ins);
		fwd_request_t r;
		r = random_request();
		r.kind = KIND_NEIGH_WR;
		r.dst_ip = key;
		r.new_dst_mac = dmac;
		r.new_src_mac = smac;
		r.port_in = port;
		r.entry_valid = ins;
		request_q.push_back(r);
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) begin
			$display("%0t: %s expected %0h actual %0h", $time, what, want, got);
			mismatches++;
		end
	endtask

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv <= '0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) begin
				forward_predict(drv, predicted);
				pending_results.push_back(predicted);
				accepted++;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (request_q.size() > 0) begin
					drv <= request_q.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (pending_results.size() == 0) begin
					$display("%0t: unexpected result, expected none actual verdict %0d",
						$time, verdict);
					mismatches++;
				end else begin
					oldest = pending_results.pop_front();
					check_field("verdict", verdict, oldest.verdict);
					check_field("ttl_out", ttl_out, oldest.ttl);
					check_field("checksum_out", checksum_out, oldest.csum);
					check_field("out_dst_mac", out_dst_mac, oldest.dmac);
					check_field("out_src_mac", out_src_mac, oldest.smac);
					check_field("egress_port", egress_port, oldest.port);
					check_field("packet_count", packet_count, oldest.count);
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (!hold_done && results_seen >= 400) begin
				// long hold-off so the pipeline backs up into in_stall
				hold_done = 1'b1;
				hold_left = 300;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 64);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
			end
		end
	end

	initial begin
		fwd_request_t r;
		logic [31:0] ra;
		logic [31:0] nh;
		logic [31:0] dip;
		logic [63:0] w1;
		logic [63:0] w2;
		int pick;
		int del_pct;
		bit ins;

		foreach (route_pool[i]) route_pool[i] = $urandom;
		foreach (hop_pool[i]) hop_pool[i] = $urandom;
		ra = route_pool[0];
		nh = hop_pool[0];

		add_packet(16'd13, ETH_IPV4, ra, 8'd64, 16'h1234);
		add_packet(16'd0, 16'h0000, ra, 8'd64, 16'h1234);
		add_packet(16'd14, 16'h86DD, ra, 8'd64, 16'h1234);
		add_packet(16'd33, ETH_IPV4, ra, 8'd64, 16'h1234);
		add_packet(16'd34, ETH_IPV4, ra, 8'd64, 16'h1234);
		add_route(ra, nh, 1'b1);
		add_packet(16'd34, ETH_IPV4, ra, 8'd64, 16'h1234);
		add_neighbor(nh, '1, '1, 16'hFFFF, 1'b1);
		add_packet(16'd60, ETH_IPV4, ra, 8'd1, 16'h1234);
		add_packet(16'd60, ETH_IPV4, ra, 8'd0, 16'h1234);
		add_packet(16'd60, ETH_IPV4, ra, 8'd2, 16'hFEFF);
		add_packet(16'hFFFF, ETH_IPV4, ra, 8'd255, 16'hFFFF);
		add_packet(16'd34, ETH_IPV4, ra, 8'd128, 16'h0000);
		add_neighbor(nh, '0, '0, 16'h0000, 1'b1);
		add_packet(16'd1500, ETH_IPV4, ra, 8'd64, 16'hB861);
		add_route(32'hFFFF_FFFF, 32'h0, 1'b1);
		add_neighbor(32'h0, 48'hA5A5_5A5A_C3C3, 48'h0123_4567_89AB, 16'h8001, 1'b1);
		add_packet(16'd64, ETH_IPV4, 32'hFFFF_FFFF, 8'd17, 16'h00FF);
		add_route(ra, nh, 1'b0);
		add_route(ra, nh, 1'b0);
		add_packet(16'd64, ETH_IPV4, ra, 8'd64, 16'h1234);
		add_neighbor(32'h0, '0, '0, 16'h0, 1'b0);
		add_neighbor(32'h0, '0, '0, 16'h0, 1'b0);
		add_packet(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF, 16'hFFFF);
		r = random_request();
		r.kind = KIND_UNUSED;
		request_q.push_back(r);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			// alternate fill-heavy and churn-heavy phases so both tables hit full
			del_pct = ((n / 400) % 2 == 0) ? 10 : 45;
			ins = ($urandom_range(0, 99) >= del_pct);
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				request_q.push_back(random_request());
			end else if (pick < 55) begin
				dip = ($urandom_range(0, 99) < 85) ? route_pool[$urandom_range(0, 79)]
					: $urandom;
				add_packet(($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 40))
						: 16'($urandom_range(34, 65535)),
					($urandom_range(0, 99) < 92) ? ETH_IPV4 : 16'($urandom),
					dip,
					($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 2))
						: 8'($urandom_range(0, 255)),
					($urandom_range(0, 19) == 0) ? 16'hFEFF : 16'($urandom));
			end else if (pick < 78) begin
				add_route(route_pool[$urandom_range(0, 79)],
					hop_pool[$urandom_range(0, 39)], ins);
			end else begin
				w1 = {$urandom, $urandom};
				w2 = {$urandom, $urandom};
				add_neighbor(hop_pool[$urandom_range(0, 39)], w1[47:0], w2[47:0],
					16'($urandom), ins);
			end
		end
		total_requests = request_q.size();

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < total_requests) @(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		if (mismatches == 0) begin
			$display("ipv4_forward_lookup_unit test passed");
		end else begin
			$display("ipv4_forward_lookup_unit test failed");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("%0t: timeout", $time);
		$display("ipv4_forward_lookup_unit test failed");
		$finish;
	end

endmodule

// File: ipv4_forward_lookup_unit.f
sv/ipv4fl_pkg.sv
sv/ipv4fl_cam.sv
sv/ipv4_forward_lookup_unit.sv
test/tb_ipv4_forward_lookup_unit.sv
